FILE: rtl/core/ssaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stick shaper package
// Types, register map and constants shared by the stick shaper block.
// ----------------------------------------------------------------------------
package ssaf_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned GAIN_FRAC  = 14;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_MODE   = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      REG_ROLL_DB   = 3'd0,
      REG_PITCH_DB  = 3'd1,
      REG_YAW_DB    = 3'd2,
      REG_ROLL_GAIN = 3'd3,
      REG_PITCH_GAIN = 3'd4,
      REG_YAW_GAIN  = 3'd5,
      REG_MAX_IVAL  = 3'd6
   } reg_index_type;

   localparam logic [2:0] MODE_OFF  = 3'd1;
   localparam logic [2:0] MODE_OPER = 3'd4;

   localparam logic signed [15:0] ARM_HI = 16'sd31130;
   localparam logic signed [15:0] ARM_LO = -16'sd31130;
   localparam logic [15:0] YAW_MIN_ALT   = 16'd3277;
   localparam logic [31:0] SHAPE_ROUND   = 32'd8192;
   localparam logic [17:0] CMD_MAX       = 18'd32767;

   localparam logic [14:0] RST_ROLL_DB   = 15'd1638;
   localparam logic [14:0] RST_PITCH_DB  = 15'd1638;
   localparam logic [14:0] RST_YAW_DB    = 15'd3277;
   localparam logic [15:0] RST_ROLL_GAIN = 16'd17246;
   localparam logic [15:0] RST_PITCH_GAIN = 16'd17246;
   localparam logic [15:0] RST_YAW_GAIN  = 16'd18204;
   localparam logic [15:0] RST_MAX_IVAL  = 16'd2000;

   typedef struct packed {
      logic [14:0] roll_db;
      logic [14:0] pitch_db;
      logic [14:0] yaw_db;
      logic [15:0] roll_gain;
      logic [15:0] pitch_gain;
      logic [15:0] yaw_gain;
      logic [15:0] max_interval_ms;
   } cfg_type;

   typedef struct packed {
      cmd_type            command;
      logic [31:0]        time_now;
      logic               axes_present;
      logic signed [15:0] roll_axis;
      logic signed [15:0] pitch_axis;
      logic signed [15:0] yaw_axis;
      logic signed [15:0] throttle_axis;
      logic [2:0]         new_mode;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] roll_out;
      logic signed [15:0] pitch_out;
      logic signed [15:0] yaw_cmd;
      logic [15:0]        alt_cmd;
      logic               motors_armed;
      logic               enable_sent;
      logic               motor_on;
      logic               estop_out;
   } rsp_payload_type;

endpackage
`default_nettype wire

FILE: rtl/core/ssaf_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface ssaf_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ssaf_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stick shaper registers
// APB-style register file holding deadbands, gains and the sample interval.
// ----------------------------------------------------------------------------
module ssaf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ssaf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [ssaf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ssaf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output ssaf_pkg::cfg_type                cfg
);
   import ssaf_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready   = 1'b1;
   assign write_en = psel & penable & pwrite;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_ROLL_DB:    cfg_in.roll_db         = pwdata[14:0];
            REG_PITCH_DB:   cfg_in.pitch_db        = pwdata[14:0];
            REG_YAW_DB:     cfg_in.yaw_db          = pwdata[14:0];
            REG_ROLL_GAIN:  cfg_in.roll_gain       = pwdata[15:0];
            REG_PITCH_GAIN: cfg_in.pitch_gain      = pwdata[15:0];
            REG_YAW_GAIN:   cfg_in.yaw_gain        = pwdata[15:0];
            REG_MAX_IVAL:   cfg_in.max_interval_ms = pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_ROLL_DB:    prdata = {17'd0, cfg_ff.roll_db};
         REG_PITCH_DB:   prdata = {17'd0, cfg_ff.pitch_db};
         REG_YAW_DB:     prdata = {17'd0, cfg_ff.yaw_db};
         REG_ROLL_GAIN:  prdata = {16'd0, cfg_ff.roll_gain};
         REG_PITCH_GAIN: prdata = {16'd0, cfg_ff.pitch_gain};
         REG_YAW_GAIN:   prdata = {16'd0, cfg_ff.yaw_gain};
         REG_MAX_IVAL:   prdata = {16'd0, cfg_ff.max_interval_ms};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.roll_db         <= RST_ROLL_DB;
         cfg_ff.pitch_db        <= RST_PITCH_DB;
         cfg_ff.yaw_db          <= RST_YAW_DB;
         cfg_ff.roll_gain       <= RST_ROLL_GAIN;
         cfg_ff.pitch_gain      <= RST_PITCH_GAIN;
         cfg_ff.yaw_gain        <= RST_YAW_GAIN;
         cfg_ff.max_interval_ms <= RST_MAX_IVAL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/ssaf_shape.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stick axis shaper
// Inverts one axis, applies the deadband, rescales by the gain and saturates.
// ----------------------------------------------------------------------------
module ssaf_shape (
   input  logic signed [15:0] raw,
   input  logic [14:0]        deadband,
   input  logic [15:0]        gain,
   output logic signed [15:0] cmd
);
   import ssaf_pkg::*;

   logic [15:0] mag;
   logic [15:0] diff;
   logic        above;
   logic [31:0] prod;
   logic [17:0] scaled;
   logic [14:0] sat;

   always_comb begin
      mag    = raw[15] ? (~raw + 16'd1) : raw;
      above  = mag > {1'b0, deadband};
      diff   = mag - {1'b0, deadband};
      prod   = ({16'd0, diff} * {16'd0, gain}) + SHAPE_ROUND;
      scaled = prod[31:GAIN_FRAC];
      sat    = (scaled > CMD_MAX) ? CMD_MAX[14:0] : scaled[14:0];
      if (!above) begin
         cmd = '0;
      end else if (raw[15]) begin
         cmd = {1'b0, sat};
      end else begin
         cmd = -$signed({1'b0, sat});
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/stick_shaper_arming_failsafe_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stick shaper with gesture arming and joystick-loss failsafe
// Shapes joystick axes into roll, pitch, yaw and altitude commands.
//
// req_if takes joystick samples, mode updates and publish ticks, one transfer
// per cycle while req_if.ready is high. rsp_if gives one command item per
// publish tick once a joystick sample has been taken; other events give none.
// psel/penable/pwrite write deadbands, gains and the sample interval at
// 4-byte spacing; pready is tied high and reads return the stored value.
// An event is held in an input register, evaluated by the shaping and
// arming logic, and its result lands in the output register. Throughput is
// one event per cycle while rsp_if is not stalled, set by the single
// evaluation stage.
// While rsp_if is stalled with a result pending, the input register still
// advances events that give no result; a tick waits in the input register
// and req_if.ready drops until the output register frees.
// Reset loads register defaults, sets mode off, disarms, clears joystick loss
// and empties both stages.
// ----------------------------------------------------------------------------
module stick_shaper_arming_failsafe_top (
   input  logic                             clock,
   input  logic                             reset,
   ssaf_stream_if.sink                      req_if,
   ssaf_stream_if.source                    rsp_if,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ssaf_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [ssaf_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ssaf_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import ssaf_pkg::*;

   cfg_type cfg;

   logic               s1_valid_ff, s1_valid_in;
   req_payload_type    s1_item_ff, s1_item_in;
   logic [2:0]         mode_ff, mode_in;
   logic               have_sample_ff, have_sample_in;
   logic               armed_ff, armed_in;
   logic               link_lost_ff, link_lost_in;
   logic [31:0]        last_time_ff, last_time_in;
   logic signed [15:0] roll_hold_ff, roll_hold_in;
   logic signed [15:0] pitch_hold_ff, pitch_hold_in;
   logic signed [15:0] yaw_hold_ff, yaw_hold_in;
   logic signed [15:0] thr_hold_ff, thr_hold_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               oper;
   logic               tick_result;
   logic               advance;
   logic               req_take;
   logic [31:0]        gap;
   logic               recent;
   logic               thr_low;
   logic [15:0]        thr_u;
   logic [16:0]        alt_sum;
   logic signed [15:0] roll_shaped, pitch_shaped, yaw_shaped;

   ssaf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ssaf_shape u_shape_roll (
      .raw (roll_hold_ff), .deadband (cfg.roll_db), .gain (cfg.roll_gain),
      .cmd (roll_shaped)
   );

   ssaf_shape u_shape_pitch (
      .raw (pitch_hold_ff), .deadband (cfg.pitch_db), .gain (cfg.pitch_gain),
      .cmd (pitch_shaped)
   );

   ssaf_shape u_shape_yaw (
      .raw (yaw_hold_ff), .deadband (cfg.yaw_db), .gain (cfg.yaw_gain),
      .cmd (yaw_shaped)
   );

   assign oper        = mode_ff == MODE_OPER;
   assign tick_result = (s1_item_ff.command == CMD_TICK) && have_sample_ff;
   assign advance     = s1_valid_ff & (~tick_result | ~rsp_valid_ff | rsp_if.ready);
   assign req_if.ready = ~s1_valid_ff | advance;
   assign req_take    = req_if.valid & req_if.ready;
   assign gap         = s1_item_ff.time_now - last_time_ff;
   assign recent      = gap < {16'd0, cfg.max_interval_ms};
   assign thr_u       = {~thr_hold_ff[15], thr_hold_ff[14:0]};
   assign alt_sum     = {1'b0, thr_u} + 17'd1;
   assign thr_low     = s1_item_ff.throttle_axis <= ARM_LO;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   always_comb begin
      s1_valid_in    = req_take | (s1_valid_ff & ~advance);
      s1_item_in     = req_take ? req_if.data : s1_item_ff;
      mode_in        = mode_ff;
      have_sample_in = have_sample_ff;
      armed_in       = armed_ff;
      link_lost_in   = link_lost_ff;
      last_time_in   = last_time_ff;
      roll_hold_in   = roll_hold_ff;
      pitch_hold_in  = pitch_hold_ff;
      yaw_hold_in    = yaw_hold_ff;
      thr_hold_in    = thr_hold_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_if.ready;
      rsp_data_in    = rsp_data_ff;

      if (advance) begin
         unique case (s1_item_ff.command)
            CMD_SAMPLE: begin
               if (s1_item_ff.axes_present) begin
                  roll_hold_in  = s1_item_ff.roll_axis;
                  pitch_hold_in = s1_item_ff.pitch_axis;
                  yaw_hold_in   = s1_item_ff.yaw_axis;
                  thr_hold_in   = s1_item_ff.throttle_axis;
                  last_time_in = s1_item_ff.time_now;
                  if (!have_sample_ff) begin
                     have_sample_in = 1'b1;
                  end else begin
                     if (oper && (gap > {16'd0, cfg.max_interval_ms})) begin
                        link_lost_in = 1'b1;
                     end
                     if (!oper) begin
                        armed_in = 1'b0;
                     end else if (armed_ff) begin
                        armed_in = ~((s1_item_ff.yaw_axis >= ARM_HI) & thr_low);
                     end else begin
                        armed_in = (s1_item_ff.yaw_axis <= ARM_LO) & thr_low;
                     end
                  end
               end
            end
            CMD_MODE: begin
               mode_in = s1_item_ff.new_mode;
            end
            CMD_TICK: begin
               if (have_sample_ff) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.roll_out      = roll_shaped;
                  rsp_data_in.pitch_out     = pitch_shaped;
                  rsp_data_in.yaw_cmd       = (thr_u >= YAW_MIN_ALT) ? yaw_shaped : '0;
                  rsp_data_in.alt_cmd       = alt_sum[16:1];
                  rsp_data_in.motors_armed  = armed_ff;
                  rsp_data_in.enable_sent   = 1'b0;
                  rsp_data_in.motor_on      = 1'b0;
                  rsp_data_in.estop_out     = 1'b0;
                  priority if (link_lost_ff) begin
                     rsp_data_in.estop_out   = 1'b1;
                     rsp_data_in.enable_sent = 1'b1;
                  end else if (recent) begin
                     rsp_data_in.enable_sent = 1'b1;
                     rsp_data_in.motor_on    = oper & armed_ff;
                  end else if (oper) begin
                     link_lost_in            = 1'b1;
                     rsp_data_in.enable_sent = 1'b1;
                  end
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         mode_ff        <= MODE_OFF;
         have_sample_ff <= 1'b0;
         armed_ff       <= 1'b0;
         link_lost_ff   <= 1'b0;
         last_time_ff   <= '0;
         roll_hold_ff   <= '0;
         pitch_hold_ff  <= '0;
         yaw_hold_ff    <= '0;
         thr_hold_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         mode_ff        <= mode_in;
         have_sample_ff <= have_sample_in;
         armed_ff       <= armed_in;
         link_lost_ff   <= link_lost_in;
         last_time_ff   <= last_time_in;
         roll_hold_ff   <= roll_hold_in;
         pitch_hold_ff  <= pitch_hold_in;
         yaw_hold_ff    <= yaw_hold_in;
         thr_hold_ff    <= thr_hold_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/ssaf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stick shaper checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ssaf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input ssaf_pkg::rsp_payload_type rsp_data
);
   import ssaf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_enable_only_sent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.enable_sent |-> !rsp_data.motor_on)
      else $error("motor enable set without enable transfer");

   a_estop_disables: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.estop_out |-> rsp_data.enable_sent && !rsp_data.motor_on)
      else $error("e-stop without motor disable");

   a_enable_needs_arm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.motor_on |-> rsp_data.motors_armed)
      else $error("motor enable while disarmed");

endmodule

bind stick_shaper_arming_failsafe_top ssaf_checker u_ssaf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);
`default_nettype wire
